// ===== src/ctls_pkg.sv =====
`timescale 1ns / 1ps

package ctls_pkg;

    // bracket depth counter width, signed
    localparam int DEPTH_BITS = 16;

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX =
        signed'({1'b0, {(DEPTH_BITS-1){1'b1}}});
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN =
        signed'({1'b1, {(DEPTH_BITS-1){1'b0}}});
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_ZERO = '0;
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE =
        signed'({{(DEPTH_BITS-1){1'b0}}, 1'b1});

    // character codes
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        MODE_CODE   = 3'd0,
        MODE_LINE   = 3'd1,
        MODE_BLOCK  = 3'd2,
        MODE_LIT    = 3'd3,
        MODE_ESC    = 3'd4,
        MODE_ABSORB = 3'd5
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t                    scan_mode;
        logic                          quote_is_single;
        logic                          star_seen;
        logic                          slash_pending;
        logic                          in_directive;
        logic signed [DEPTH_BITS-1:0]  bracket_depth;
        logic                          prev_was_newline;
        logic                          at_text_start;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        scan_mode:        MODE_CODE,
        quote_is_single:  1'b0,
        star_seen:        1'b0,
        slash_pending:    1'b0,
        in_directive:     1'b0,
        bracket_depth:    DEPTH_ZERO,
        prev_was_newline: 1'b1,
        at_text_start:    1'b1
    };

    // byte handed to the scanner when a pipeline stage moves
    typedef struct packed {
        logic       step;
        logic [7:0] data;
        logic       last;
    } scan_beat_t;

endpackage

// ===== src/ctls_scanner.sv =====
`timescale 1ns / 1ps

module ctls_scanner
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctls_pkg::scan_beat_t    beat,
    output logic                    segment_start
);

    ctls_pkg::scan_state_t state_reg;
    ctls_pkg::scan_state_t state_next;

    // plain code byte: directives, literals, brackets, cuts
    function automatic ctls_pkg::scan_state_t code_byte(
        input ctls_pkg::scan_state_t s_in,
        input logic [7:0]            b
    );
        ctls_pkg::scan_state_t s;
        s = s_in;
        if (b == ctls_pkg::CH_HASH && s.prev_was_newline)
        begin
            s.in_directive = 1'b1;
        end
        if (b == ctls_pkg::CH_SLASH)
        begin
            s.slash_pending = 1'b1;
        end
        else if (b == ctls_pkg::CH_DQUOTE || b == ctls_pkg::CH_SQUOTE)
        begin
            s.scan_mode       = ctls_pkg::MODE_LIT;
            s.quote_is_single = (b == ctls_pkg::CH_SQUOTE);
        end
        else
        begin
            if (b == ctls_pkg::CH_LBRACE || b == ctls_pkg::CH_LPAREN ||
                b == ctls_pkg::CH_LBRACK)
            begin
                if (s.bracket_depth != ctls_pkg::DEPTH_MAX)
                begin
                    s.bracket_depth = s.bracket_depth + ctls_pkg::DEPTH_ONE;
                end
            end
            else if (b == ctls_pkg::CH_RBRACE || b == ctls_pkg::CH_RPAREN ||
                     b == ctls_pkg::CH_RBRACK)
            begin
                if (s.bracket_depth != ctls_pkg::DEPTH_MIN)
                begin
                    s.bracket_depth = s.bracket_depth - ctls_pkg::DEPTH_ONE;
                end
            end
            if (s.in_directive && b == ctls_pkg::CH_LF)
            begin
                s.in_directive = 1'b0;
                s.scan_mode    = ctls_pkg::MODE_ABSORB;
            end
            else if (s.bracket_depth == ctls_pkg::DEPTH_ZERO &&
                     (b == ctls_pkg::CH_SEMI || b == ctls_pkg::CH_RBRACE))
            begin
                s.scan_mode = ctls_pkg::MODE_ABSORB;
            end
        end
        return s;
    endfunction

    logic is_blank;

    assign is_blank = (beat.data == ctls_pkg::CH_SPACE) || (beat.data == ctls_pkg::CH_TAB) ||
                      (beat.data == ctls_pkg::CH_LF) || (beat.data == ctls_pkg::CH_CR);

    always_comb
    begin
        state_next    = state_reg;
        segment_start = state_reg.at_text_start;
        case (state_reg.scan_mode)
            ctls_pkg::MODE_ABSORB:
            begin
                if (!is_blank)
                begin
                    segment_start        = 1'b1;
                    state_next.scan_mode = ctls_pkg::MODE_CODE;
                    state_next           = code_byte(state_next, beat.data);
                end
            end
            ctls_pkg::MODE_LINE:
            begin
                if (beat.data == ctls_pkg::CH_LF)
                begin
                    state_next.scan_mode = ctls_pkg::MODE_CODE;
                    state_next           = code_byte(state_next, beat.data);
                end
            end
            ctls_pkg::MODE_BLOCK:
            begin
                if (state_reg.star_seen && beat.data == ctls_pkg::CH_SLASH)
                begin
                    state_next.scan_mode = ctls_pkg::MODE_CODE;
                    state_next.star_seen = 1'b0;
                end
                else
                begin
                    state_next.star_seen = (beat.data == ctls_pkg::CH_STAR);
                end
            end
            ctls_pkg::MODE_LIT:
            begin
                if (beat.data == ctls_pkg::CH_BSLASH)
                begin
                    state_next.scan_mode = ctls_pkg::MODE_ESC;
                end
                else if (beat.data == (state_reg.quote_is_single ?
                                       ctls_pkg::CH_SQUOTE : ctls_pkg::CH_DQUOTE))
                begin
                    state_next.scan_mode = ctls_pkg::MODE_CODE;
                end
            end
            ctls_pkg::MODE_ESC:
            begin
                state_next.scan_mode = ctls_pkg::MODE_LIT;
            end
            default:
            begin
                // code mode, unused codes fall in here too
                state_next.scan_mode = ctls_pkg::MODE_CODE;
                if (state_reg.slash_pending && beat.data == ctls_pkg::CH_SLASH)
                begin
                    state_next.slash_pending = 1'b0;
                    state_next.scan_mode     = ctls_pkg::MODE_LINE;
                end
                else if (state_reg.slash_pending && beat.data == ctls_pkg::CH_STAR)
                begin
                    state_next.slash_pending = 1'b0;
                    state_next.scan_mode     = ctls_pkg::MODE_BLOCK;
                    state_next.star_seen     = 1'b0;
                end
                else
                begin
                    state_next.slash_pending = 1'b0;
                    state_next               = code_byte(state_next, beat.data);
                end
            end
        endcase
        state_next.prev_was_newline = (beat.data == ctls_pkg::CH_LF);
        state_next.at_text_start    = 1'b0;
        if (beat.last)
        begin
            state_next = ctls_pkg::SCAN_RESET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctls_pkg::SCAN_RESET;
        end
        else if (beat.step)
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/cpp_top_level_segmenter_unit.sv =====
`timescale 1ns / 1ps

// C++ top-level segmenter: takes source text one byte per beat and passes each
// byte through, with m_tuser high on a byte that begins a new top-level segment.
// Comments, string and char literals are skipped; a segment ends after a ';' or
// '}' at bracket depth zero, or at the newline closing a '#' directive, and any
// blanks right after the cut stay with the old segment. The first byte of a
// text always starts a segment and s_tlast returns the scanner to its reset
// state after that byte. One byte is accepted per clock when the output side
// is ready; a byte moves from the input register into the result register once
// that register is free or being drained, and the scanner state is updated in
// that same move.

module cpp_top_level_segmenter_unit
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] source_byte
    input  logic       s_tlast,     // last_byte

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] echo_byte
    output logic       m_tuser,     // [0] segment_start
    output logic       m_tlast      // end_of_text
);

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // result register
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_start_reg;
    logic       out_last_reg;

    logic                 advance;
    logic                 s_accept;
    logic                 seg_start;
    ctls_pkg::scan_beat_t beat;

    // byte moves into the result register when that slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign beat.step = advance;
    assign beat.data = in_byte_reg;
    assign beat.last = in_last_reg;

    ctls_scanner u_scanner
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .beat          (beat),
        .segment_start (seg_start)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            out_byte_reg  <= in_byte_reg;
            out_start_reg <= seg_start;
            out_last_reg  <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_start_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // one result beat as the block should present it
    typedef struct packed {
        logic [7:0] echo_byte;
        logic       segment_start;
        logic       end_of_text;
    } seg_mark_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;     // [7:0] source_byte
    logic       s_tlast = 1'b0;      // last_byte

    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;             // [7:0] echo_byte
    logic       m_tuser;             // [0] segment_start
    logic       m_tlast;             // end_of_text

    // idling control shared by the stimulus tasks and the result sink
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int hold_cycles = 0;

    int        fails = 0;
    seg_mark_t expected_marks[$];

    // scanner state kept by the predictor
    ctls_pkg::scan_mode_t                   mode;
    logic                                   single_quote;
    logic                                   star;
    logic                                   slash;
    logic                                   directive;
    logic signed [ctls_pkg::DEPTH_BITS-1:0] depth;
    logic                                   prev_lf;
    logic                                   at_start;

    cpp_top_level_segmenter_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void reset_scanner();
        mode         = ctls_pkg::MODE_CODE;
        single_quote = 1'b0;
        star         = 1'b0;
        slash        = 1'b0;
        directive    = 1'b0;
        depth        = ctls_pkg::DEPTH_ZERO;
        prev_lf      = 1'b1;
        at_start     = 1'b1;
    endfunction

    // append one byte at the tail of a byte queue
    function automatic void append_byte(ref logic [7:0] q[$], input logic [7:0] b);
        q.insert(q.size(), b);
    endfunction

    // a byte seen as plain code
    function automatic void code_step(input logic [7:0] b);
        if (b == ctls_pkg::CH_HASH && prev_lf)
            directive = 1'b1;
        if (b == ctls_pkg::CH_SLASH)
        begin
            slash = 1'b1;
            return;
        end
        if (b == ctls_pkg::CH_DQUOTE || b == ctls_pkg::CH_SQUOTE)
        begin
            mode         = ctls_pkg::MODE_LIT;
            single_quote = (b == ctls_pkg::CH_SQUOTE);
            return;
        end
        if (b == ctls_pkg::CH_LBRACE || b == ctls_pkg::CH_LPAREN ||
            b == ctls_pkg::CH_LBRACK)
        begin
            if (depth < ctls_pkg::DEPTH_MAX)
                depth = depth + ctls_pkg::DEPTH_ONE;
        end
        else if (b == ctls_pkg::CH_RBRACE || b == ctls_pkg::CH_RPAREN ||
                 b == ctls_pkg::CH_RBRACK)
        begin
            if (depth > ctls_pkg::DEPTH_MIN)
                depth = depth - ctls_pkg::DEPTH_ONE;
        end
        if (directive && b == ctls_pkg::CH_LF)
        begin
            directive = 1'b0;
            mode      = ctls_pkg::MODE_ABSORB;
            return;
        end
        if (depth == ctls_pkg::DEPTH_ZERO &&
            (b == ctls_pkg::CH_SEMI || b == ctls_pkg::CH_RBRACE))
            mode = ctls_pkg::MODE_ABSORB;
    endfunction

    function automatic seg_mark_t scan_byte(input logic [7:0] b, input logic last);
        seg_mark_t r;
        r.echo_byte     = b;
        r.segment_start = at_start;
        r.end_of_text   = last;
        case (mode)
            ctls_pkg::MODE_ABSORB:
            begin
                if (!(b == ctls_pkg::CH_SPACE || b == ctls_pkg::CH_TAB ||
                      b == ctls_pkg::CH_LF || b == ctls_pkg::CH_CR))
                begin
                    r.segment_start = 1'b1;
                    mode            = ctls_pkg::MODE_CODE;
                    code_step(b);
                end
            end
            ctls_pkg::MODE_LINE:
            begin
                // the closing newline counts as code
                if (b == ctls_pkg::CH_LF)
                begin
                    mode = ctls_pkg::MODE_CODE;
                    code_step(b);
                end
            end
            ctls_pkg::MODE_BLOCK:
            begin
                if (star && b == ctls_pkg::CH_SLASH)
                begin
                    mode = ctls_pkg::MODE_CODE;
                    star = 1'b0;
                end
                else
                    star = (b == ctls_pkg::CH_STAR);
            end
            ctls_pkg::MODE_LIT:
            begin
                if (b == ctls_pkg::CH_BSLASH)
                    mode = ctls_pkg::MODE_ESC;
                else if (b == (single_quote ? ctls_pkg::CH_SQUOTE : ctls_pkg::CH_DQUOTE))
                    mode = ctls_pkg::MODE_CODE;
            end
            ctls_pkg::MODE_ESC:
                mode = ctls_pkg::MODE_LIT;
            default:
            begin
                mode = ctls_pkg::MODE_CODE;
                if (slash && b == ctls_pkg::CH_SLASH)
                begin
                    slash = 1'b0;
                    mode  = ctls_pkg::MODE_LINE;
                end
                else if (slash && b == ctls_pkg::CH_STAR)
                begin
                    // opening star never closes the comment
                    slash = 1'b0;
                    mode  = ctls_pkg::MODE_BLOCK;
                    star  = 1'b0;
                end
                else
                begin
                    slash = 1'b0;
                    code_step(b);
                end
            end
        endcase
        prev_lf  = (b == ctls_pkg::CH_LF);
        at_start = 1'b0;
        if (last)
            reset_scanner();
        return r;
    endfunction

    // offer one source byte, wait for the beat, record what should come out
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        expected_marks.insert(expected_marks.size(), scan_byte(b, last));
    endtask

    task automatic send_seq(ref logic [7:0] q[$]);
        for (int i = 0; i < q.size(); i++)
            send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic send_text(input string s);
        logic [7:0] q[$];
        for (int i = 0; i < s.len(); i++)
            append_byte(q, s[i]);
        send_seq(q);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_marks.size() != 0)
            @(posedge clk);
        // pipeline is two stages deep
        repeat (4) @(posedge clk);
    endtask

    // append one random piece of source text, mostly well formed
    function automatic void add_fragment(ref logic [7:0] q[$]);
        logic [7:0] blanks[4];
        logic [7:0] closers[6];
        logic [7:0] quote;
        int n;
        blanks  = '{ctls_pkg::CH_SPACE, ctls_pkg::CH_TAB, ctls_pkg::CH_LF, ctls_pkg::CH_CR};
        closers = '{ctls_pkg::CH_LPAREN, ctls_pkg::CH_RPAREN, ctls_pkg::CH_LBRACK,
                    ctls_pkg::CH_RBRACK, ctls_pkg::CH_LBRACE, ctls_pkg::CH_RBRACE};
        case ($urandom_range(0, 11))
            0, 1:
            begin
                n = $urandom_range(1, 6);
                repeat (n) append_byte(q, 8'(8'h61 + $urandom_range(0, 25)));
            end
            2:
            begin
                n = $urandom_range(1, 3);
                repeat (n) append_byte(q, blanks[$urandom_range(0, 3)]);
            end
            3: append_byte(q, ctls_pkg::CH_SEMI);
            4: append_byte(q, $urandom_range(0, 1) ? ctls_pkg::CH_LBRACE : ctls_pkg::CH_RBRACE);
            5: append_byte(q, closers[$urandom_range(0, 5)]);
            6:
            begin
                append_byte(q, ctls_pkg::CH_SLASH);
                append_byte(q, ctls_pkg::CH_SLASH);
                n = $urandom_range(0, 4);
                repeat (n) append_byte(q, $urandom_range(0, 1) ? ctls_pkg::CH_STAR : 8'h63);
                append_byte(q, ctls_pkg::CH_LF);
            end
            7:
            begin
                append_byte(q, ctls_pkg::CH_SLASH);
                append_byte(q, ctls_pkg::CH_STAR);
                n = $urandom_range(0, 5);
                repeat (n)
                begin
                    case ($urandom_range(0, 3))
                        0: append_byte(q, ctls_pkg::CH_STAR);
                        1: append_byte(q, ctls_pkg::CH_SLASH);
                        2: append_byte(q, ctls_pkg::CH_LF);
                        default: append_byte(q, 8'h62);
                    endcase
                end
                append_byte(q, ctls_pkg::CH_STAR);
                append_byte(q, ctls_pkg::CH_SLASH);
            end
            8:
            begin
                quote = $urandom_range(0, 1) ? ctls_pkg::CH_SQUOTE : ctls_pkg::CH_DQUOTE;
                append_byte(q, quote);
                n = $urandom_range(0, 4);
                repeat (n)
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            append_byte(q, ctls_pkg::CH_BSLASH);
                            append_byte(q, $urandom_range(0, 1) ? quote : ctls_pkg::CH_BSLASH);
                        end
                        1: append_byte(q, quote == ctls_pkg::CH_SQUOTE ?
                                          ctls_pkg::CH_DQUOTE : ctls_pkg::CH_SQUOTE);
                        2: append_byte(q, ctls_pkg::CH_SEMI);
                        default: append_byte(q, 8'(8'h61 + $urandom_range(0, 25)));
                    endcase
                end
                append_byte(q, quote);
            end
            9:
            begin
                append_byte(q, ctls_pkg::CH_LF);
                append_byte(q, ctls_pkg::CH_HASH);
                append_byte(q, 8'h69);
                if ($urandom_range(0, 1))
                    append_byte(q, ctls_pkg::CH_LBRACE);
                if ($urandom_range(0, 2) == 0)
                begin
                    append_byte(q, ctls_pkg::CH_SLASH);
                    append_byte(q, ctls_pkg::CH_SLASH);
                end
                append_byte(q, ctls_pkg::CH_LF);
            end
            10:
            begin
                n = $urandom_range(1, 3);
                repeat (n) append_byte(q, 8'($urandom_range(0, 255)));
            end
            default:
            begin
                append_byte(q, ctls_pkg::CH_SLASH);
                if ($urandom_range(0, 1))
                    append_byte(q, ctls_pkg::CH_SPACE);
            end
        endcase
    endfunction

    task automatic send_random_texts(input int count);
        logic [7:0] q[$];
        int sent;
        int pieces;
        sent = 0;
        while (sent < count)
        begin
            q.delete();
            pieces = $urandom_range(1, 12);
            repeat (pieces) add_fragment(q);
            send_seq(q);
            sent += q.size();
        end
    endtask

    task automatic test_directed();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        // cut at ';' with the blanks after it absorbed
        send_text("a; \t\r\nb}");
        // directive at text start, line comment newline closes it, then a new one
        send_text("#i//\n#x\n;");
        // slash star slash stays in the comment, escaped quotes in literals
        send_text("/*/x*/'\\'';\"\\\"\"}");
        // byte extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // comment left open at the last byte
        send_text("x/*");
        send_text("/");
        wait_drained();
    endtask

    task automatic test_random();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_random_texts(550);
        wait_drained();
    endtask

    // sink stops for a long time while bytes keep coming
    task automatic test_backpressure();
        send_idle   = 1'b0;
        recv_idle   = 1'b1;
        hold_cycles = 300;
        send_random_texts(60);
        wait_drained();
    endtask

    task automatic test_no_idle();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_random_texts(150);
        wait_drained();
    endtask

    // brackets nest both ways; a cut only follows back at depth zero
    task automatic test_depth_nesting();
        send_idle = 1'b0;
        recv_idle = 1'b1;
        repeat (40) send_byte(ctls_pkg::CH_LPAREN, 1'b0);
        repeat (40) send_byte(ctls_pkg::CH_RPAREN, 1'b0);
        send_byte(ctls_pkg::CH_SEMI, 1'b0);
        send_byte(8'h78, 1'b1);
        repeat (20) send_byte(ctls_pkg::CH_RPAREN, 1'b0);
        repeat (20) send_byte(ctls_pkg::CH_LPAREN, 1'b0);
        send_byte(ctls_pkg::CH_SEMI, 1'b0);
        send_byte(8'h78, 1'b1);
        wait_drained();
    endtask

    initial
    begin
        reset_scanner();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        test_no_idle();
        test_depth_nesting();
        wait_drained();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result sink: random stalls, plus one long hold when asked
    initial
    begin : result_sink
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            else
                stall = recv_idle ? $urandom_range(0, 14) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // compare every output beat with the oldest prediction
    always @(posedge clk)
    begin
        seg_mark_t exp_mark;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_marks.size() == 0)
            begin
                $error("unexpected beat: echo_byte %h", m_tdata);
                fails++;
            end
            else
            begin
                exp_mark = expected_marks.pop_front();
                if (m_tdata !== exp_mark.echo_byte)
                begin
                    $error("echo_byte: expected %h, got %h", exp_mark.echo_byte, m_tdata);
                    fails++;
                end
                if (m_tuser !== exp_mark.segment_start)
                begin
                    $error("segment_start: expected %b, got %b",
                           exp_mark.segment_start, m_tuser);
                    fails++;
                end
                if (m_tlast !== exp_mark.end_of_text)
                begin
                    $error("end_of_text: expected %b, got %b", exp_mark.end_of_text, m_tlast);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== cpp_top_level_segmenter_unit.f =====
src/ctls_pkg.sv
src/ctls_scanner.sv
src/cpp_top_level_segmenter_unit.sv
tb/sv/tb.sv
